/* rtl/qlwt_pkg.sv */
// Shared constants, codes and control structs for the quorum log watermark tracker.
// Depends on nothing; every other file in rtl/ imports it.
package qlwt_pkg;

  localparam int MAX_MEMBERS_DEF = 8;

  localparam int MASK_W     = 8;
  localparam int COUNT_W    = 4;
  localparam int LIMIT_W    = 32;
  localparam int ID_W       = 64;
  localparam int TIME_W     = 63;
  localparam int SLOT_IN_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_MEMBER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLICA_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRESH_LIMIT   = 2'd2;

  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [COUNT_W-1:0] REPLICA_COUNT_RST = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPORT,
    ST_SCAN,
    ST_INSERT,
    ST_FINISH
  } state_t;

  // Commands to the ranking unit.
  typedef struct packed {
    logic clear;
    logic min_en;
    logic ins_start;
  } rank_ctl_t;

  // Status from the ranking unit.
  typedef struct packed {
    logic busy;
    logic enough;
  } rank_sts_t;

  // Commands to the entry store.
  typedef struct packed {
    logic prune;
    logic write;
  } ent_ctl_t;

endpackage

/* rtl/qlwt_if.sv */
// Channel interfaces of the tracker: item input, result output, register writes.
// Depends on qlwt_pkg for field widths.
interface qlwt_item_if;
  import qlwt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SLOT_IN_W-1:0] member_slot;
  logic                 is_log_only;
  logic [ID_W-1:0]      confirmed_id;
  logic [TIME_W-1:0]    now_time;
  modport source (output valid, mode, member_slot, is_log_only, confirmed_id, now_time,
                  input ready);
  modport sink   (input valid, mode, member_slot, is_log_only, confirmed_id, now_time,
                  output ready);
endinterface

interface qlwt_result_if;
  import qlwt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     recyclable_id;
  logic                members_complete;
  modport source (output valid, status, recyclable_id, members_complete, input ready);
  modport sink   (input valid, status, recyclable_id, members_complete, output ready);
endinterface

interface qlwt_cfg_if;
  import qlwt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/qlwt_entries.sv */
// Per-slot entry store: valid bits (cleared at reset), log-only flag, id and stamp.
// Depends on qlwt_pkg.
module qlwt_entries #(
  parameter int MAX_MEMBERS = qlwt_pkg::MAX_MEMBERS_DEF,
  localparam int SLOT_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qlwt_pkg::ent_ctl_t           ctl,
  input  logic [MAX_MEMBERS-1:0]       members,
  input  logic [SLOT_W-1:0]            wr_slot,
  input  logic                         wr_log_only,
  input  logic [qlwt_pkg::ID_W-1:0]    wr_id,
  input  logic [qlwt_pkg::TIME_W-1:0]  wr_stamp,
  input  logic [SLOT_W-1:0]            rd_slot,
  output logic                         rd_valid,
  output logic                         rd_log_only,
  output logic [qlwt_pkg::ID_W-1:0]    rd_id,
  output logic [qlwt_pkg::TIME_W-1:0]  rd_stamp
);
  import qlwt_pkg::*;

  logic [MAX_MEMBERS-1:0] valid;
  logic [MAX_MEMBERS-1:0] valid_next;
  logic                   log_only [MAX_MEMBERS];
  logic [ID_W-1:0]        conf     [MAX_MEMBERS];
  logic [TIME_W-1:0]      stamp    [MAX_MEMBERS];

  // Drop entries of non-members first, then mark the written slot.
  always_comb begin
    valid_next = ctl.prune ? (valid & members) : valid;
    if (ctl.write) begin
      valid_next[wr_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      log_only[wr_slot] <= wr_log_only;
      conf[wr_slot]     <= wr_id;
      stamp[wr_slot]    <= wr_stamp;
    end
  end

  assign rd_valid    = valid[rd_slot];
  assign rd_log_only = log_only[rd_slot];
  assign rd_id       = conf[rd_slot];
  assign rd_stamp    = stamp[rd_slot];

endmodule

/* rtl/qlwt_rank.sv */
// Ranking unit: descending sorted id list built by insertion, plus a running minimum,
// both served by one shared 64-bit less-than comparator. Depends on qlwt_pkg.
module qlwt_rank #(
  parameter int MAX_MEMBERS = qlwt_pkg::MAX_MEMBERS_DEF,
  localparam int SLOT_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1,
  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qlwt_pkg::rank_ctl_t          ctl,
  input  logic [qlwt_pkg::ID_W-1:0]    id_in,
  input  logic [qlwt_pkg::COUNT_W-1:0] majority,
  output qlwt_pkg::rank_sts_t          sts,
  output logic [qlwt_pkg::ID_W-1:0]    kth,
  output logic [qlwt_pkg::ID_W-1:0]    low
);
  import qlwt_pkg::*;

  localparam int EXT_W = SLOT_W + COUNT_W;
  localparam int CMP_W = CNT_W + COUNT_W;

  logic [ID_W-1:0]    sorted [MAX_MEMBERS];
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   ins_pos;
  logic [CNT_W-1:0]   ins_pos_m1;
  logic [ID_W-1:0]    ins_val;
  logic               busy;
  logic [COUNT_W-1:0] maj_m1;
  logic [EXT_W-1:0]   maj_ext;
  logic [SLOT_W-1:0]  rd_idx;
  logic [ID_W-1:0]    rd_data;
  logic [ID_W-1:0]    op_a;
  logic [ID_W-1:0]    op_b;
  logic               lt;
  logic               shift;

  assign ins_pos_m1 = ins_pos - 1'b1;
  assign maj_m1     = majority - 1'b1;
  assign maj_ext    = EXT_W'(maj_m1);

  // One read port: the neighbor above the hole while inserting, else the quorum rank.
  assign rd_idx  = busy ? ins_pos_m1[SLOT_W-1:0] : maj_ext[SLOT_W-1:0];
  assign rd_data = sorted[rd_idx];

  // Shared comparator: insertion step while busy, minimum update otherwise.
  assign op_a  = busy ? rd_data : id_in;
  assign op_b  = busy ? ins_val : low;
  assign lt    = op_a < op_b;
  assign shift = (ins_pos != '0) && lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      n       <= '0;
      ins_pos <= '0;
    end else if (ctl.clear) begin
      busy <= 1'b0;
      n    <= '0;
    end else if (ctl.ins_start) begin
      busy    <= 1'b1;
      ins_pos <= n;
    end else if (busy) begin
      if (shift) begin
        ins_pos <= ins_pos_m1;
      end else begin
        busy <= 1'b0;
        n    <= n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      low <= '1;
    end else if (ctl.min_en && lt) begin
      low <= id_in;
    end
    if (ctl.ins_start) begin
      ins_val <= id_in;
    end
    if (busy) begin
      sorted[ins_pos[SLOT_W-1:0]] <= shift ? rd_data : ins_val;
    end
  end

  assign kth        = rd_data;
  assign sts.busy   = busy;
  assign sts.enough = CMP_W'(n) >= CMP_W'(majority);

endmodule

/* rtl/quorum_log_watermark_tracker_core.sv */
// Quorum log watermark tracker. One item is taken at a time; a report goes through the
// REPORT state into the output register, while a query scans every slot (SCAN), inserts
// the id of every fresh full member into the ranking unit's sorted list (INSERT) and then
// loads its answer (FINISH). The ranking unit's single 64-bit comparator steps the sorted
// list one position per cycle. The result sits in an output register, so the next item is
// taken while it waits. Registers are written in one beat at any time; write
// them only while the block is idle. Depends on qlwt_pkg, qlwt_if, qlwt_entries, qlwt_rank.
module quorum_log_watermark_tracker_core #(
  parameter int MAX_MEMBERS = qlwt_pkg::MAX_MEMBERS_DEF
) (
  input logic           clk,
  input logic           rst,
  qlwt_item_if.sink     item,
  qlwt_result_if.source result,
  qlwt_cfg_if.sink      cfg
);
  import qlwt_pkg::*;

  localparam int SLOT_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);

  // Configuration registers.
  logic [MASK_W-1:0]  member_mask;
  logic [COUNT_W-1:0] replica_count;
  logic [LIMIT_W-1:0] freshness_limit;

  // Captured item.
  logic                 req_mode;
  logic [SLOT_IN_W-1:0] req_slot;
  logic                 req_log_only;
  logic [ID_W-1:0]      req_id;
  logic [TIME_W-1:0]    req_now;

  // Sequencer.
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] scan_cnt;
  logic             complete;

  // Output register.
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic                res_complete;

  logic                out_free;
  logic                out_load;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic                out_complete;

  logic [MAX_MEMBERS-1:0] member_vec;
  logic                   item_accept;
  logic                   slot_member;
  logic [SLOT_W-1:0]      wr_idx;

  ent_ctl_t          ent_ctl;
  logic              rd_valid;
  logic              rd_log_only;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_stamp;

  rank_ctl_t          rank_ctl;
  rank_sts_t          rank_sts;
  logic [COUNT_W-1:0] majority;
  logic [ID_W-1:0]    kth;
  logic [ID_W-1:0]    low;
  logic [ID_W-1:0]    kth_sel;
  logic [ID_W-1:0]    answer;

  logic [TIME_W:0] age;
  logic            fresh;
  logic            scan_mem;
  logic            scan_present;
  logic            scan_last;

  // Slots beyond the mask width are never members.
  for (genvar s = 0; s < MAX_MEMBERS; s++) begin : g_member
    if (s < MASK_W) begin : g_in
      assign member_vec[s] = member_mask[s];
    end else begin : g_out
      assign member_vec[s] = 1'b0;
    end
  end

  assign item.ready  = (state == ST_IDLE);
  assign item_accept = item.valid && item.ready;
  assign cfg.ready   = 1'b1;

  // Register writes land in one beat; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      member_mask     <= '0;
      replica_count   <= REPLICA_COUNT_RST;
      freshness_limit <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MEMBER_MASK:   member_mask     <= cfg.data[MASK_W-1:0];
        REG_REPLICA_COUNT: replica_count   <= cfg.data[COUNT_W-1:0];
        REG_FRESH_LIMIT:   freshness_limit <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the item for the whole sequence.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      req_mode     <= item.mode;
      req_slot     <= item.member_slot;
      req_log_only <= item.is_log_only;
      req_id       <= item.confirmed_id;
      req_now      <= item.now_time;
    end
  end

  assign wr_idx      = SLOT_W'(req_slot);
  assign slot_member = (32'(req_slot) < MAX_MEMBERS) && member_vec[wr_idx];

  qlwt_entries #(.MAX_MEMBERS(MAX_MEMBERS)) u_entries (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ent_ctl),
    .members     (member_vec),
    .wr_slot     (wr_idx),
    .wr_log_only (req_log_only),
    .wr_id       (req_id),
    .wr_stamp    (req_now),
    .rd_slot     (scan_cnt[SLOT_W-1:0]),
    .rd_valid    (rd_valid),
    .rd_log_only (rd_log_only),
    .rd_id       (rd_id),
    .rd_stamp    (rd_stamp)
  );

  // Age goes negative when the stamp lies after now; such an entry counts as fresh.
  assign age   = {1'b0, req_now} - {1'b0, rd_stamp};
  assign fresh = age[TIME_W] || (age[TIME_W-1:0] <= TIME_W'(freshness_limit));

  assign scan_mem     = member_vec[scan_cnt[SLOT_W-1:0]];
  assign scan_present = rd_valid && fresh;
  assign scan_last    = (scan_cnt == CNT_W'(MAX_MEMBERS - 1));

  // Majority is count/2 + 1.
  assign majority = {1'b0, replica_count[COUNT_W-1:1]} + 1'b1;

  qlwt_rank #(.MAX_MEMBERS(MAX_MEMBERS)) u_rank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rank_ctl),
    .id_in    (rd_id),
    .majority (majority),
    .sts      (rank_sts),
    .kth      (kth),
    .low      (low)
  );

  // Quorum answer, falling back to the minimum when every member is present and it is zero.
  assign kth_sel = rank_sts.enough ? kth : '0;
  assign answer  = (complete && (kth_sel == '0)) ? low : kth_sel;

  assign out_free = !res_valid || result.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_accept) begin
          state_next = (item.mode == MODE_QUERY) ? ST_SCAN : ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (rank_ctl.ins_start) begin
          state_next = ST_INSERT;
        end else if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_INSERT: begin
        if (!rank_sts.busy) begin
          state_next = (scan_cnt == CNT_W'(MAX_MEMBERS)) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ent_ctl      = '0;
    rank_ctl     = '0;
    out_load     = 1'b0;
    out_status   = STATUS_OK;
    out_id       = '0;
    out_complete = 1'b0;
    case (state)
      ST_IDLE: begin
        rank_ctl.clear = item_accept && (item.mode == MODE_QUERY);
      end
      ST_REPORT: begin
        // Update only in the beat that also loads the result, so it happens once.
        if (out_free) begin
          out_load = 1'b1;
          if (req_id == '1) begin
            out_status = STATUS_BAD_ID;
          end else begin
            ent_ctl.prune = 1'b1;
            ent_ctl.write = slot_member;
            out_status    = slot_member ? STATUS_OK : STATUS_NOT_MEMBER;
          end
        end
      end
      ST_SCAN: begin
        rank_ctl.min_en    = scan_mem && rd_valid && !rd_log_only;
        rank_ctl.ins_start = scan_mem && scan_present && !rd_log_only;
      end
      ST_INSERT: ;
      ST_FINISH: begin
        out_load     = out_free;
        out_id       = answer;
        out_complete = complete;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      complete <= 1'b0;
    end else begin
      state <= state_next;
      if (item_accept) begin
        scan_cnt <= '0;
        complete <= 1'b1;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_mem && !scan_present) begin
          complete <= 1'b0;
        end
      end
    end
  end

  // Output register: load on a free slot, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_status   <= out_status;
      res_id       <= out_id;
      res_complete <= out_complete;
    end
  end

  assign result.valid            = res_valid;
  assign result.status           = res_status;
  assign result.recyclable_id    = res_id;
  assign result.members_complete = res_complete;

endmodule

/* rtl/qlwt_checker.sv */
// Port-level checks for the tracker and the bind that attaches them to the top level.
// Depends on qlwt_pkg and quorum_log_watermark_tracker_core.
module qlwt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [qlwt_pkg::STATUS_W-1:0] res_status,
  input logic [qlwt_pkg::ID_W-1:0]     res_id,
  input logic                          res_complete
);
  import qlwt_pkg::*;

  logic [1:0] outstanding;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = item_valid && item_ready;
  assign out_beat = res_valid && res_ready;

  // Track items taken whose result has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped before its beat");

  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != STATUS_OK) |-> (res_id == '0) && !res_complete)
    else $error("failed report carries a query answer");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> outstanding != 2'd0)
    else $error("result shown with no item outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two items in flight");

endmodule

bind quorum_log_watermark_tracker_core qlwt_checker u_qlwt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_status   (result.status),
  .res_id       (result.recyclable_id),
  .res_complete (result.members_complete)
);
